/* design/saa_pkg.sv */
// Shared types, constants and codes of the shelf atlas allocator.
package saa_pkg;

   // Atlas geometry and shelf table size.
   localparam int ATLAS_SIZE  = 1024;
   localparam int MAX_SHELVES = 256;

   // Derived widths.
   localparam int POS_W   = $clog2(ATLAS_SIZE);
   localparam int COORD_W = POS_W + 1;
   localparam int SUM_W   = POS_W + 2;
   localparam int IDX_W   = $clog2(MAX_SHELVES);
   localparam int CNT_W   = IDX_W + 1;
   localparam int GEN_W   = 32;
   localparam int PAD_W   = 4;
   localparam int STAT_W  = 2;

   localparam logic [PAD_W-1:0]   PAD_RESET   = PAD_W'(2);
   localparam logic [SUM_W-1:0]   ATLAS_SUM   = SUM_W'(ATLAS_SIZE);
   localparam logic [COORD_W-1:0] ATLAS_COORD = COORD_W'(ATLAS_SIZE);
   localparam logic [CNT_W-1:0]   MAX_COUNT   = CNT_W'(MAX_SHELVES);

   // Item kinds.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Result status codes.
   typedef enum logic [STAT_W-1:0] {
      STATUS_PLACED      = 2'd0,
      STATUS_PLACED_WRAP = 2'd1,
      STATUS_REJECTED    = 2'd2,
      STATUS_CLEARED     = 2'd3
   } status_type;

   // One shelf table entry.
   typedef struct packed {
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] fill_x;
      logic [COORD_W-1:0] row_height;
   } shelf_type;

   localparam int SHELF_W = $bits(shelf_type);

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_PLACE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic finish_check;
      logic scan;
      logic place;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_clear;
      logic too_big;
      logic no_shelves;
      logic scan_last;
   } dp_status_type;

endpackage

/* design/saa_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module saa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/saa_datapath.sv */
// Datapath of the shelf atlas allocator: shelf table, scan, placement and result registers.
module saa_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  saa_pkg::dp_cmd_type             cmd,
   output saa_pkg::dp_status_type          stat,
   input  logic                            req_kind,
   input  logic [saa_pkg::COORD_W-1:0]     req_rect_width,
   input  logic [saa_pkg::COORD_W-1:0]     req_rect_height,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [saa_pkg::PAD_W-1:0]       csr_pad,
   output logic                            rsp_strobe,
   output logic [saa_pkg::STAT_W-1:0]      rsp_status,
   output logic [saa_pkg::POS_W-1:0]       rsp_pos_x,
   output logic [saa_pkg::POS_W-1:0]       rsp_pos_y,
   output logic [saa_pkg::GEN_W-1:0]       rsp_generation,
   output logic [saa_pkg::COORD_W-1:0]     rsp_dirty_min_row,
   output logic [saa_pkg::COORD_W-1:0]     rsp_dirty_max_row
);

   // Configuration and block state.
   logic [saa_pkg::PAD_W-1:0]   pad_ff;
   logic [saa_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [saa_pkg::COORD_W-1:0] next_row_ff, next_row_in;
   logic [saa_pkg::GEN_W-1:0]   gen_ff, gen_in;
   logic [saa_pkg::COORD_W-1:0] dirty_low_ff, dirty_low_in;
   logic [saa_pkg::COORD_W-1:0] dirty_high_ff, dirty_high_in;

   // Captured transaction.
   logic                        kind_ff;
   logic [saa_pkg::COORD_W-1:0] w_ff, h_ff;

   // Scan pipeline and best-fit tracking.
   logic [saa_pkg::CNT_W-1:0]   issue_ff;
   logic                        cmp_valid_ff;
   logic [saa_pkg::IDX_W-1:0]   cmp_idx_ff;
   logic                        found_ff;
   logic [saa_pkg::IDX_W-1:0]   best_idx_ff;
   logic [saa_pkg::SUM_W-1:0]   best_h_ff;
   logic [saa_pkg::COORD_W-1:0] best_top_ff, best_fill_ff;

   // Result registers.
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [saa_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [saa_pkg::POS_W-1:0]   rsp_pos_x_ff, rsp_pos_x_in;
   logic [saa_pkg::POS_W-1:0]   rsp_pos_y_ff, rsp_pos_y_in;

   // Shelf RAM ports.
   logic                        rd_en;
   saa_pkg::shelf_type          rd_shelf;
   logic                        wr_en;
   logic [saa_pkg::IDX_W-1:0]   wr_addr;
   saa_pkg::shelf_type          wr_shelf;

   // Padded sizes and fit test.
   logic [saa_pkg::SUM_W-1:0]   w_pad, h_pad, fit_sum;
   logic                        fits;
   logic                        wrap;
   logic [saa_pkg::COORD_W-1:0] place_x, place_y;
   logic [saa_pkg::SUM_W-1:0]   place_bottom;

   assign csr_ready = 1'b1;

   assign w_pad = saa_pkg::SUM_W'(w_ff) + saa_pkg::SUM_W'(pad_ff);
   assign h_pad = saa_pkg::SUM_W'(h_ff) + saa_pkg::SUM_W'(pad_ff);

   // Status toward the controller.
   always_comb begin
      stat.is_clear   = (kind_ff == saa_pkg::KIND_CLEAR);
      stat.too_big    = (w_pad > saa_pkg::ATLAS_SUM) || (h_pad > saa_pkg::ATLAS_SUM);
      stat.no_shelves = (count_ff == '0);
      stat.scan_last  = cmp_valid_ff &&
                        ((saa_pkg::CNT_W'(cmp_idx_ff) + saa_pkg::CNT_W'(1)) == count_ff);
   end

   // Shelf table.
   saa_ram #(
      .WIDTH(saa_pkg::SHELF_W),
      .DEPTH(saa_pkg::MAX_SHELVES)
   ) u_shelf_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_shelf),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[saa_pkg::IDX_W-1:0]),
      .rd_data (rd_shelf)
   );

   // Read issue during the scan, one entry per cycle.
   assign rd_en = cmd.scan && (issue_ff < count_ff);

   // Fit test on the entry that comes back from the RAM.
   always_comb begin
      fit_sum = saa_pkg::SUM_W'(rd_shelf.fill_x) + w_pad;
      fits    = (h_ff <= rd_shelf.row_height) &&
                (fit_sum <= saa_pkg::ATLAS_SUM) &&
                (saa_pkg::SUM_W'(rd_shelf.row_height) < best_h_ff);
   end

   // Placement: reuse the best shelf or open a new one, wrapping when needed.
   always_comb begin
      wrap = !found_ff &&
             (((saa_pkg::SUM_W'(next_row_ff) + h_pad) > saa_pkg::ATLAS_SUM) ||
              (count_ff == saa_pkg::MAX_COUNT));
      if (found_ff) begin
         place_x = best_fill_ff;
         place_y = best_top_ff;
      end else begin
         place_x = '0;
         place_y = wrap ? '0 : next_row_ff;
      end
      place_bottom = saa_pkg::SUM_W'(place_y) + saa_pkg::SUM_W'(h_ff);

      wr_en               = cmd.place;
      wr_shelf.top        = place_y;
      if (found_ff) begin
         wr_addr             = best_idx_ff;
         wr_shelf.fill_x     = saa_pkg::COORD_W'(saa_pkg::SUM_W'(best_fill_ff) + w_pad);
         wr_shelf.row_height = best_h_ff[saa_pkg::COORD_W-1:0];
      end else begin
         wr_addr             = wrap ? '0 : count_ff[saa_pkg::IDX_W-1:0];
         wr_shelf.fill_x     = saa_pkg::COORD_W'(w_pad);
         wr_shelf.row_height = h_ff;
      end
   end

   // Next state and result values.
   always_comb begin
      count_in      = count_ff;
      next_row_in   = next_row_ff;
      gen_in        = gen_ff;
      dirty_low_in  = dirty_low_ff;
      dirty_high_in = dirty_high_ff;
      rsp_strobe_in = cmd.finish_check || cmd.place;
      rsp_status_in = rsp_status_ff;
      rsp_pos_x_in  = rsp_pos_x_ff;
      rsp_pos_y_in  = rsp_pos_y_ff;

      if (cmd.finish_check) begin
         rsp_pos_x_in = '0;
         rsp_pos_y_in = '0;
         if (stat.is_clear) begin
            dirty_low_in  = saa_pkg::ATLAS_COORD;
            dirty_high_in = '0;
            rsp_status_in = saa_pkg::STATUS_CLEARED;
         end else begin
            rsp_status_in = saa_pkg::STATUS_REJECTED;
         end
      end

      if (cmd.place) begin
         if (!found_ff) begin
            count_in    = wrap ? saa_pkg::CNT_W'(1) : count_ff + saa_pkg::CNT_W'(1);
            next_row_in = saa_pkg::COORD_W'(saa_pkg::SUM_W'(place_y) + h_pad);
         end
         if (wrap) begin
            gen_in        = gen_ff + saa_pkg::GEN_W'(1);
            dirty_low_in  = '0;
            dirty_high_in = saa_pkg::ATLAS_COORD;
         end
         if (place_y < dirty_low_in) begin
            dirty_low_in = place_y;
         end
         if (place_bottom > saa_pkg::SUM_W'(dirty_high_in)) begin
            dirty_high_in = saa_pkg::COORD_W'(place_bottom);
         end
         rsp_status_in = wrap ? saa_pkg::STATUS_PLACED_WRAP : saa_pkg::STATUS_PLACED;
         rsp_pos_x_in  = place_x[saa_pkg::POS_W-1:0];
         rsp_pos_y_in  = place_y[saa_pkg::POS_W-1:0];
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff        <= saa_pkg::PAD_RESET;
         count_ff      <= '0;
         next_row_ff   <= '0;
         gen_ff        <= '0;
         dirty_low_ff  <= saa_pkg::ATLAS_COORD;
         dirty_high_ff <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            pad_ff <= csr_pad;
         end
         count_ff      <= count_in;
         next_row_ff   <= next_row_in;
         gen_ff        <= gen_in;
         dirty_low_ff  <= dirty_low_in;
         dirty_high_ff <= dirty_high_in;
         cmp_valid_ff  <= rd_en;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Transaction capture, scan tracking and result payload.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         w_ff      <= req_rect_width;
         h_ff      <= req_rect_height;
         issue_ff  <= '0;
         found_ff  <= 1'b0;
         best_h_ff <= '1;
      end else if (cmd.scan) begin
         if (rd_en) begin
            issue_ff <= issue_ff + saa_pkg::CNT_W'(1);
         end
         if (cmp_valid_ff && fits) begin
            found_ff     <= 1'b1;
            best_idx_ff  <= cmp_idx_ff;
            best_h_ff    <= saa_pkg::SUM_W'(rd_shelf.row_height);
            best_top_ff  <= rd_shelf.top;
            best_fill_ff <= rd_shelf.fill_x;
         end
      end
      cmp_idx_ff    <= issue_ff[saa_pkg::IDX_W-1:0];
      rsp_status_ff <= rsp_status_in;
      rsp_pos_x_ff  <= rsp_pos_x_in;
      rsp_pos_y_ff  <= rsp_pos_y_in;
   end

   // Result ports; generation and dirty span are the state after the transaction.
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_pos_x         = rsp_pos_x_ff;
   assign rsp_pos_y         = rsp_pos_y_ff;
   assign rsp_generation    = gen_ff;
   assign rsp_dirty_min_row = dirty_low_ff;
   assign rsp_dirty_max_row = dirty_high_ff;

endmodule

/* design/saa_ctrl.sv */
// Controller state machine of the shelf atlas allocator.
module saa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  saa_pkg::dp_status_type stat,
   output saa_pkg::dp_cmd_type    cmd
);

   saa_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= saa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         saa_pkg::ST_IDLE: begin
            if (start) begin
               state_in = saa_pkg::ST_CHECK;
            end
         end
         saa_pkg::ST_CHECK: begin
            if (stat.is_clear || stat.too_big) begin
               state_in = saa_pkg::ST_IDLE;
            end else if (stat.no_shelves) begin
               state_in = saa_pkg::ST_PLACE;
            end else begin
               state_in = saa_pkg::ST_SCAN;
            end
         end
         saa_pkg::ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = saa_pkg::ST_PLACE;
            end
         end
         saa_pkg::ST_PLACE: begin
            state_in = saa_pkg::ST_IDLE;
         end
         default: begin
            state_in = saa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      busy             = 1'b1;
      cmd.load         = 1'b0;
      cmd.finish_check = 1'b0;
      cmd.scan         = 1'b0;
      cmd.place        = 1'b0;
      unique case (state_ff)
         saa_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         saa_pkg::ST_CHECK: begin
            cmd.finish_check = stat.is_clear || stat.too_big;
         end
         saa_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         saa_pkg::ST_PLACE: begin
            cmd.place = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

/* design/shelf_atlas_allocator_core.sv */
// Top level of the shelf atlas allocator: controller and datapath.
//
//   Channel   Direction  Handshake            Payload
//   request   in         start && !busy       req_kind, req_rect_width, req_rect_height
//   response  out        rsp_strobe (1 cycle) rsp_status, rsp_pos_x, rsp_pos_y,
//                                             rsp_generation, rsp_dirty_min_row/max_row
//   csr       in         csr_valid && ready   csr_pad
//
// A clear or rejected transaction ends in the check state, and the registered strobe
// follows. An allocation passes through the check, scan and place states, with the scan
// skipped when no shelf is open; the scan reads one shelf entry per cycle from the
// single read port of the shelf RAM, one entry for each open shelf.
// Synchronous reset restores pad to 2, empties the shelf table, zeroes the generation
// and empties the dirty span; the shelf RAM itself needs no clearing pass.
// The response strobe lasts one cycle and the receiver cannot stall it; start is taken
// again in the cycle the strobe shows.
module shelf_atlas_allocator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_kind,
   input  logic [saa_pkg::COORD_W-1:0] req_rect_width,
   input  logic [saa_pkg::COORD_W-1:0] req_rect_height,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [saa_pkg::PAD_W-1:0]   csr_pad,
   output logic                        rsp_strobe,
   output logic [saa_pkg::STAT_W-1:0]  rsp_status,
   output logic [saa_pkg::POS_W-1:0]   rsp_pos_x,
   output logic [saa_pkg::POS_W-1:0]   rsp_pos_y,
   output logic [saa_pkg::GEN_W-1:0]   rsp_generation,
   output logic [saa_pkg::COORD_W-1:0] rsp_dirty_min_row,
   output logic [saa_pkg::COORD_W-1:0] rsp_dirty_max_row
);

   saa_pkg::dp_cmd_type    cmd;
   saa_pkg::dp_status_type stat;

   // Sequencing of each transaction.
   saa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Shelf table, fit scan and result registers.
   saa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_rect_width    (req_rect_width),
      .req_rect_height   (req_rect_height),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_pad           (csr_pad),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_generation    (rsp_generation),
      .rsp_dirty_min_row (rsp_dirty_min_row),
      .rsp_dirty_max_row (rsp_dirty_max_row)
   );

endmodule
